/* hdl/cubic_bezier_path_sampler_macros.svh */
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - assertion macros
// Shared concurrent check forms used by the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_PATH_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_PATH_SAMPLER_MACROS_SVH

// same-cycle implication
`define CBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbps: same-cycle check failed");

// next-cycle implication
`define CBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbps: next-cycle check failed");

`endif

/* hdl/cbps_pkg.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cbps_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int AXES            = 3;
   localparam int CNT_W           = 6;
   localparam logic [CNT_W-1:0] SEG_COUNT_RESET = CNT_W'(16);
   // two registered stages per lerp level, three levels
   localparam int PIPE_DEPTH      = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic             load_knot;
      logic             div_init;
      logic             div_step;
      logic             issue;
      logic             last;
      logic [CNT_W-1:0] idx;
      logic [CNT_W-1:0] seg_n;
   } ctrl_cmd_type;

   typedef struct packed {
      logic adv;
      logic pipe_busy;
   } dp_status_type;

endpackage

/* hdl/cbps_ctrl.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - controller
// Knot handshake, segment count register, divider sequencing, sample issue.
// ----------------------------------------------------------------------------
`include "cubic_bezier_path_sampler_macros.svh"

module cbps_ctrl
   import cbps_pkg::*;
#(
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  dp_status_type    sts,
   output ctrl_cmd_type     cmd
);

   localparam int STEP_W = $clog2(T_FRAC_BITS + 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(T_FRAC_BITS);

   ctrl_state_type   state_ff, state_in;
   logic             have_prev_ff, have_prev_in;
   logic [CNT_W-1:0] segcnt_ff, segcnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] n_eff;
   logic             accept;

   assign n_eff  = (segcnt_ff == '0) ? CNT_W'(1) : segcnt_ff;
   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && have_prev_ff) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (sts.adv && (idx_ff == n_eff)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = 1'b0;
      cmd.load_knot = accept;
      cmd.div_init  = accept;
      cmd.div_step  = 1'b0;
      cmd.issue     = 1'b0;
      cmd.last      = (idx_ff == n_eff);
      cmd.idx       = idx_ff;
      cmd.seg_n     = n_eff;
      unique case (state_ff)
         ST_IDLE: req_tready   = !sts.pipe_busy;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_RUN:  cmd.issue    = sts.adv;
         default: req_tready   = 1'b0;
      endcase
   end

   // counters and registers
   always_comb begin
      have_prev_in = have_prev_ff | accept;
      segcnt_in    = csr_we ? csr_wdata : segcnt_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      if (accept) begin
         step_in = '0;
         idx_in  = '0;
      end else begin
         if (state_ff == ST_DIV) step_in = step_ff + STEP_W'(1);
         if (cmd.issue)          idx_in  = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         segcnt_ff    <= SEG_COUNT_RESET;
         step_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         segcnt_ff    <= segcnt_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
      end
   end

   `CBPS_ASSERT_NOW(a_ready_needs_empty_pipe, clock, reset, req_tready, !sts.pipe_busy)
   `CBPS_ASSERT_NEXT(a_last_issue_ends_run, clock, reset, cmd.issue && cmd.last, state_ff == ST_IDLE)
   `CBPS_ASSERT_NEXT(a_first_knot_no_run, clock, reset, accept && !have_prev_ff, state_ff == ST_IDLE)
   `CBPS_ASSERT_NEXT(a_knot_starts_div, clock, reset, accept && have_prev_ff, state_ff == ST_DIV)

endmodule

/* hdl/cbps_lerp.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - interpolation stage
// y = a + floor(t * (b - a) / 2^T_FRAC_BITS), product stage then add stage.
// ----------------------------------------------------------------------------
module cbps_lerp
   import cbps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] a,
   input  logic signed [COORD_WIDTH-1:0] b,
   input  logic        [T_FRAC_BITS:0]   t,
   output logic signed [COORD_WIDTH-1:0] y
);

   localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;

   logic signed [COORD_WIDTH:0]   diff;
   logic signed [T_FRAC_BITS+1:0] t_s;
   logic signed [PW-1:0]          prod_in, prod_ff;
   logic signed [COORD_WIDTH-1:0] a_ff, y_in, y_ff;

   assign diff    = $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
   assign t_s     = $signed({1'b0, t});
   assign prod_in = t_s * diff;
   // arithmetic shift of the product is a floor; result stays between a and b
   assign y_in    = a_ff + prod_ff[T_FRAC_BITS +: COORD_WIDTH];
   assign y       = y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a;
         prod_ff <= prod_in;
         y_ff    <= y_in;
      end
   end

endmodule

/* hdl/cbps_dp.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - datapath
// Knot storage, t generator (restoring divider plus stepper) and the
// three-level de Casteljau pipeline with its output register.
// ----------------------------------------------------------------------------
module cbps_dp
   import cbps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          sts,
   input  logic [COORD_WIDTH-1:0] anchor   [AXES],
   input  logic [COORD_WIDTH-1:0] in_ctrl  [AXES],
   input  logic [COORD_WIDTH-1:0] out_ctrl [AXES],
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [COORD_WIDTH-1:0] curve    [AXES],
   output logic [CNT_W-1:0]       sample_idx,
   output logic                   sample_last
);

   localparam int TW = T_FRAC_BITS + 1;
   localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

   logic [COORD_WIDTH-1:0] prev_anchor_ff [AXES];
   logic [COORD_WIDTH-1:0] prev_out_ff    [AXES];
   logic [COORD_WIDTH-1:0] seg_p0_ff      [AXES];
   logic [COORD_WIDTH-1:0] seg_c0_ff      [AXES];
   logic [COORD_WIDTH-1:0] seg_c1_ff      [AXES];
   logic [COORD_WIDTH-1:0] seg_p1_ff      [AXES];

   // divider and t stepper
   logic [TW-1:0]    dvd_ff, dvd_in;
   logic [TW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [TW-1:0]    tq_ff, tq_in;
   logic [CNT_W-1:0] tr_ff, tr_in;
   logic [CNT_W:0]   n_ext, rem_sh, tr_sum;
   logic             rem_ge, tr_wrap;
   logic [TW-1:0]    t_issue;

   // pipeline control and side info
   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [TW-1:0]         t_pipe_ff    [4];
   logic [CNT_W-1:0]      idx_pipe_ff  [PIPE_DEPTH];
   logic                  last_pipe_ff [PIPE_DEPTH];

   assign n_ext   = {1'b0, cmd.seg_n};
   assign rem_sh  = {rem_ff, dvd_ff[TW-1]};
   assign rem_ge  = (rem_sh >= n_ext);
   assign tr_sum  = {1'b0, tr_ff} + {1'b0, rem_ff};
   assign tr_wrap = (tr_sum >= n_ext);
   assign t_issue = cmd.last ? T_ONE : tq_ff;

   always_comb begin
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      tq_in  = tq_ff;
      tr_in  = tr_ff;
      if (cmd.div_init) begin
         dvd_in = T_ONE;
         quo_in = '0;
         rem_in = '0;
         tq_in  = '0;
         tr_in  = '0;
      end else if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         quo_in = {quo_ff[TW-2:0], rem_ge};
         rem_in = rem_ge ? CNT_W'(rem_sh - n_ext) : CNT_W'(rem_sh);
      end else if (cmd.issue) begin
         // t(i+1) = t(i) + floor(2^F/n), plus carry from the remainder sum
         tq_in = tq_ff + quo_ff + TW'(tr_wrap);
         tr_in = tr_wrap ? CNT_W'(tr_sum - n_ext) : CNT_W'(tr_sum);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      tq_ff  <= tq_in;
      tr_ff  <= tr_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_knot) begin
         for (int k = 0; k < AXES; k++) begin
            seg_p0_ff[k]      <= prev_anchor_ff[k];
            seg_c0_ff[k]      <= prev_out_ff[k];
            seg_c1_ff[k]      <= in_ctrl[k];
            seg_p1_ff[k]      <= anchor[k];
            prev_anchor_ff[k] <= anchor[k];
            prev_out_ff[k]    <= out_ctrl[k];
         end
      end
   end

   // whole pipeline moves when the output register is free or being taken
   assign adv           = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign sts.adv       = adv;
   assign sts.pipe_busy = |vld_ff[PIPE_DEPTH-2:0];
   assign vld_in        = {vld_ff[PIPE_DEPTH-2:0], cmd.issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_pipe_ff[0]    <= t_issue;
         idx_pipe_ff[0]  <= cmd.idx;
         last_pipe_ff[0] <= cmd.last;
         for (int s = 1; s < 4; s++) t_pipe_ff[s] <= t_pipe_ff[s-1];
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            idx_pipe_ff[s]  <= idx_pipe_ff[s-1];
            last_pipe_ff[s] <= last_pipe_ff[s-1];
         end
      end
   end

   for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
      logic signed [COORD_WIDTH-1:0] l0, l1, l2, m0, m1, pt;

      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_l0 (
         .clock(clock), .en(adv), .a(seg_p0_ff[ax]), .b(seg_c0_ff[ax]),
         .t(t_issue), .y(l0));
      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_l1 (
         .clock(clock), .en(adv), .a(seg_c0_ff[ax]), .b(seg_c1_ff[ax]),
         .t(t_issue), .y(l1));
      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_l2 (
         .clock(clock), .en(adv), .a(seg_c1_ff[ax]), .b(seg_p1_ff[ax]),
         .t(t_issue), .y(l2));
      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_m0 (
         .clock(clock), .en(adv), .a(l0), .b(l1), .t(t_pipe_ff[1]), .y(m0));
      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_m1 (
         .clock(clock), .en(adv), .a(l1), .b(l2), .t(t_pipe_ff[1]), .y(m1));
      cbps_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_pt (
         .clock(clock), .en(adv), .a(m0), .b(m1), .t(t_pipe_ff[3]), .y(pt));

      assign curve[ax] = pt;
   end

   assign rsp_valid   = vld_ff[PIPE_DEPTH-1];
   assign sample_idx  = idx_pipe_ff[PIPE_DEPTH-1];
   assign sample_last = last_pipe_ff[PIPE_DEPTH-1];

endmodule

/* hdl/cubic_bezier_path_sampler.sv */
// Sequence: after a knot is taken the bit-serial divider forms the t step, then samples
//   issue and pass through the six-stage interpolation pipeline. Throughput: one sample per
//   cycle while rsp_tready does not stall the output; the next knot is taken only once the
//   pipeline has drained up to its output register.
// Reset: synchronous, active high; clears the state machine, the knot history flag,
//   the pipeline valids and loads segment_count with 16.
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler - top level
// Samples the cubic segment between consecutive path knots by de Casteljau.
// ----------------------------------------------------------------------------
module cubic_bezier_path_sampler
   import cbps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [CNT_W-1:0]                       csr_wdata,   // segment_count
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // anchor_x, anchor_y, anchor_z, in_ctrl_x, in_ctrl_y, in_ctrl_z,
   // out_ctrl_x, out_ctrl_y, out_ctrl_z
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // curve_x, curve_y, curve_z, sample_index
   output logic [((3*COORD_WIDTH+CNT_W+7)/8)*8-1:0] rsp_tdata,
   output logic                                   rsp_tlast    // last_sample
);

   localparam int RSP_W = ((3*COORD_WIDTH + CNT_W + 7) / 8) * 8;

   ctrl_cmd_type           cmd;
   dp_status_type          sts;
   logic [COORD_WIDTH-1:0] anchor   [AXES];
   logic [COORD_WIDTH-1:0] in_ctrl  [AXES];
   logic [COORD_WIDTH-1:0] out_ctrl [AXES];
   logic [COORD_WIDTH-1:0] curve    [AXES];
   logic [CNT_W-1:0]       sample_idx;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         anchor[k]   = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
         in_ctrl[k]  = req_tdata[(AXES+k)*COORD_WIDTH +: COORD_WIDTH];
         out_ctrl[k] = req_tdata[(2*AXES+k)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   assign rsp_tdata = RSP_W'({sample_idx, curve[2], curve[1], curve[0]});

   cbps_ctrl #(.T_FRAC_BITS(T_FRAC_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbps_dp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .anchor      (anchor),
      .in_ctrl     (in_ctrl),
      .out_ctrl    (out_ctrl),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .curve       (curve),
      .sample_idx  (sample_idx),
      .sample_last (rsp_tlast)
   );

endmodule
